// ----- sv/kvc_pkg.sv -----
// shared constants, codes and control types of the keyed tableau vigenere core
package kvc_pkg;

  localparam int unsigned ALPHA     = 26;
  localparam int unsigned ALPHA_W   = 5;
  localparam int unsigned KEY_MAX   = 64;
  localparam int unsigned KEY_AW    = 6;
  localparam int unsigned KLEN_W    = 7;
  localparam int unsigned CHAR_W    = 8;
  localparam int unsigned TAB_DEPTH = ALPHA * ALPHA;
  localparam int unsigned TAB_AW    = 10;
  localparam int unsigned TDATA_W   = 32;
  localparam int unsigned TUSER_W   = 2;
  localparam int unsigned OUT_W     = 8;

  typedef enum logic [1:0] {
    OP_TAB_LOAD = 2'd0,
    OP_KEY_LOAD = 2'd1,
    OP_DECRYPT  = 2'd2,
    OP_ENCRYPT  = 2'd3
  } kvc_op_e;

  typedef enum logic [2:0] {
    ST_IDLE = 3'd0,
    ST_KEY  = 3'd1,
    ST_FIND = 3'd2,
    ST_SCAN = 3'd3,
    ST_READ = 3'd4,
    ST_EMIT = 3'd5
  } kvc_state_e;

  typedef struct packed {
    logic take;          // input transaction accepted
    logic lookup;        // register row and row-0 column matches
    logic enc_rd;        // read the cell at matched row and column
    logic scan_start;    // read column 0 of the matched row
    logic scan_next;     // read the next column of the matched row
    logic res_from_scan; // result is the row-0 cell of the scan column
    logic res_from_mem;  // result is the cell just read
    logic emit;          // move the result into the output register
  } kvc_cmd_t;

  typedef struct packed {
    logic in_text;    // incoming transaction is a text character
    logic op_enc;     // current character is encrypted
    logic row_hit;
    logic col_hit;
    logic scan_match;
    logic scan_last;
    logic out_free;
  } kvc_sts_t;

endpackage

// ----- sv/kvc_ctrl.sv -----
// controller state machine of the keyed tableau vigenere core
module kvc_ctrl (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              s_valid_i,
  output logic              s_ready_o,
  input  kvc_pkg::kvc_sts_t sts_i,
  output kvc_pkg::kvc_cmd_t cmd_o
);
  import kvc_pkg::*;

  kvc_state_e state_q, state_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  always_comb begin
    state_d   = state_q;
    cmd_o     = '0;
    s_ready_o = 1'b0;
    case (state_q)
      ST_IDLE: begin
        s_ready_o = 1'b1;
        if (s_valid_i) begin
          cmd_o.take = 1'b1;
          if (sts_i.in_text) begin
            state_d = ST_KEY;
          end
        end
      end
      ST_KEY: begin
        cmd_o.lookup = 1'b1;
        state_d      = ST_FIND;
      end
      ST_FIND: begin
        if (!sts_i.row_hit) begin
          state_d = ST_IDLE;
        end else if (sts_i.op_enc) begin
          if (sts_i.col_hit) begin
            cmd_o.enc_rd = 1'b1;
            state_d      = ST_READ;
          end else begin
            state_d = ST_IDLE;
          end
        end else begin
          cmd_o.scan_start = 1'b1;
          state_d          = ST_SCAN;
        end
      end
      ST_SCAN: begin
        if (sts_i.scan_match) begin
          cmd_o.res_from_scan = 1'b1;
          state_d             = ST_EMIT;
        end else if (sts_i.scan_last) begin
          state_d = ST_IDLE;
        end else begin
          cmd_o.scan_next = 1'b1;
        end
      end
      ST_READ: begin
        cmd_o.res_from_mem = 1'b1;
        state_d            = ST_EMIT;
      end
      ST_EMIT: begin
        if (sts_i.out_free) begin
          cmd_o.emit = 1'b1;
          state_d    = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  // never overwrite a result that has not been taken
  assert property (@(posedge clk_i) disable iff (!rst_ni) cmd_o.emit |-> sts_i.out_free)
    else $error("result emitted into a busy output register");

  // the column scan stops at the last column
  assert property (@(posedge clk_i) disable iff (!rst_ni) cmd_o.scan_next |-> !sts_i.scan_last)
    else $error("column scan ran past the row");

  // an encrypt read needs both a row and a column match
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_o.enc_rd |-> (sts_i.row_hit && sts_i.col_hit))
    else $error("encrypt read without a full match");

endmodule

// ----- sv/kvc_datapath.sv -----
// datapath of the keyed tableau vigenere core: storage, matching and result registers
module kvc_datapath (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          cfg_we_i,
  input  logic [kvc_pkg::KLEN_W-1:0]    cfg_wdata_i,
  input  logic [kvc_pkg::TDATA_W-1:0]   in_data_i,
  input  logic [kvc_pkg::TUSER_W-1:0]   in_user_i,
  input  kvc_pkg::kvc_cmd_t             cmd_i,
  output kvc_pkg::kvc_sts_t             sts_o,
  output logic                          out_valid_o,
  input  logic                          out_ready_i,
  output logic [kvc_pkg::OUT_W-1:0]     out_data_o
);
  import kvc_pkg::*;

  // input fields
  kvc_op_e             in_op;
  logic [ALPHA_W-1:0]  in_row;
  logic [ALPHA_W-1:0]  in_col;
  logic [KEY_AW-1:0]   in_kidx;
  logic [CHAR_W-1:0]   in_char;
  logic                in_first;

  assign in_op    = kvc_op_e'(in_user_i);
  assign in_row   = in_data_i[4:0];
  assign in_col   = in_data_i[9:5];
  assign in_kidx  = in_data_i[15:10];
  assign in_char  = in_data_i[23:16];
  assign in_first = in_data_i[24];

  // key length register and effective length
  logic [KLEN_W-1:0] klen_q;
  logic [KLEN_W-1:0] eff_len;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      klen_q <= KLEN_W'(1);
    end else if (cfg_we_i) begin
      klen_q <= cfg_wdata_i;
    end
  end

  always_comb begin
    if (klen_q == '0) begin
      eff_len = KLEN_W'(1);
    end else if (klen_q > KLEN_W'(KEY_MAX)) begin
      eff_len = KLEN_W'(KEY_MAX);
    end else begin
      eff_len = klen_q;
    end
  end

  // key position
  logic [KEY_AW-1:0] key_pos_q, key_pos_d;
  logic [KEY_AW-1:0] pos_raw, pos_sel;
  logic [KLEN_W-1:0] pos_inc;
  logic              take_text;
  logic              take_tab;
  logic              take_key;
  logic              tab_in_range;

  assign take_text    = cmd_i.take && (in_op == OP_DECRYPT || in_op == OP_ENCRYPT);
  assign take_key     = cmd_i.take && (in_op == OP_KEY_LOAD);
  assign tab_in_range = (in_row < ALPHA_W'(ALPHA)) && (in_col < ALPHA_W'(ALPHA));
  assign take_tab     = cmd_i.take && (in_op == OP_TAB_LOAD) && tab_in_range;

  always_comb begin
    pos_raw   = in_first ? '0 : key_pos_q;
    pos_sel   = ({1'b0, pos_raw} >= eff_len) ? '0 : pos_raw;
    pos_inc   = {1'b0, pos_sel} + KLEN_W'(1);
    key_pos_d = (pos_inc >= eff_len) ? '0 : pos_inc[KEY_AW-1:0];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      key_pos_q <= '0;
    end else if (take_text) begin
      key_pos_q <= key_pos_d;
    end
  end

  // key store
  logic [CHAR_W-1:0] key_mem [KEY_MAX];
  logic [CHAR_W-1:0] key_rd_q;

  always_ff @(posedge clk_i) begin
    if (take_key) begin
      key_mem[in_kidx] <= in_char;
    end
    if (cmd_i.take) begin
      key_rd_q <= key_mem[pos_sel];
    end
  end

  // text character and mode of the item in flight
  logic [CHAR_W-1:0] char_q;
  logic              op_enc_q;

  always_ff @(posedge clk_i) begin
    if (cmd_i.take) begin
      char_q   <= in_char;
      op_enc_q <= (in_op == OP_ENCRYPT);
    end
  end

  // copies of row 0 and column 0 for parallel matching
  logic [CHAR_W-1:0] row0_q [ALPHA];
  logic [CHAR_W-1:0] col0_q [ALPHA];

  always_ff @(posedge clk_i) begin
    if (take_tab && in_row == '0) begin
      row0_q[in_col] <= in_char;
    end
    if (take_tab && in_col == '0) begin
      col0_q[in_row] <= in_char;
    end
  end

  // lowest row keyed by the key character, lowest row-0 column holding the text
  logic [ALPHA_W-1:0] row_d, row_q, col_d, col_q;
  logic               row_hit_d, row_hit_q, col_hit_d, col_hit_q;

  always_comb begin
    row_d     = '0;
    row_hit_d = 1'b0;
    col_d     = '0;
    col_hit_d = 1'b0;
    for (int j = ALPHA - 1; j >= 0; j--) begin
      if (col0_q[j] == key_rd_q) begin
        row_d     = ALPHA_W'(j);
        row_hit_d = 1'b1;
      end
      if (row0_q[j] == char_q) begin
        col_d     = ALPHA_W'(j);
        col_hit_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.lookup) begin
      row_q     <= row_d;
      row_hit_q <= row_hit_d;
      col_q     <= col_d;
      col_hit_q <= col_hit_d;
    end
  end

  // tableau memory and column scan
  logic [CHAR_W-1:0]  tab_mem [TAB_DEPTH];
  logic [CHAR_W-1:0]  tab_rd_q;
  logic [TAB_AW-1:0]  tab_waddr, tab_raddr, row_base;
  logic [ALPHA_W-1:0] cnt_q, cnt_inc;

  assign tab_waddr = TAB_AW'(in_row) * TAB_AW'(ALPHA) + TAB_AW'(in_col);
  assign row_base  = TAB_AW'(row_q) * TAB_AW'(ALPHA);
  assign cnt_inc   = cnt_q + ALPHA_W'(1);

  always_comb begin
    if (cmd_i.enc_rd) begin
      tab_raddr = row_base + TAB_AW'(col_q);
    end else if (cmd_i.scan_next) begin
      tab_raddr = row_base + TAB_AW'(cnt_inc);
    end else begin
      tab_raddr = row_base;
    end
  end

  always_ff @(posedge clk_i) begin
    if (take_tab) begin
      tab_mem[tab_waddr] <= in_char;
    end
    tab_rd_q <= tab_mem[tab_raddr];
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.scan_start) begin
      cnt_q <= '0;
    end else if (cmd_i.scan_next) begin
      cnt_q <= cnt_inc;
    end
  end

  // result and output register
  logic [CHAR_W-1:0] res_q;
  logic [OUT_W-1:0]  out_q;
  logic              out_valid_q;

  always_ff @(posedge clk_i) begin
    if (cmd_i.res_from_scan) begin
      res_q <= row0_q[cnt_q];
    end else if (cmd_i.res_from_mem) begin
      res_q <= tab_rd_q;
    end
    if (cmd_i.emit) begin
      out_q <= res_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (cmd_i.emit) begin
      out_valid_q <= 1'b1;
    end else if (out_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

  always_comb begin
    sts_o            = '0;
    sts_o.in_text    = (in_op == OP_DECRYPT || in_op == OP_ENCRYPT);
    sts_o.op_enc     = op_enc_q;
    sts_o.row_hit    = row_hit_q;
    sts_o.col_hit    = col_hit_q;
    sts_o.scan_match = (tab_rd_q == char_q);
    sts_o.scan_last  = (cnt_q == ALPHA_W'(ALPHA - 1));
    sts_o.out_free   = !out_valid_q || out_ready_i;
  end

  // key position moves only when a text character is taken
  assert property (@(posedge clk_i) disable iff (!rst_ni) !take_text |=> $stable(key_pos_q))
    else $error("key position changed without a text character");

endmodule

// ----- sv/keyed_tableau_vigenere_cipher_core.sv -----
// top level of the keyed tableau vigenere cipher core
// loads (tableau cell, key character) are accepted back to back while the controller is idle
// encrypt: key read, row and column match, one tableau read, result stage; the next item is
//   accepted after the result moves to the output register; no-match items end after the match
// decrypt: key read and row match, then a column scan through the tableau memory read port
//   up to the matching column, or to the last column when no column matches
// reset clears control, key position (0) and key length (1); tableau and key store are not cleared
module keyed_tableau_vigenere_cipher_core (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  // key length register write
  input  logic                          cfg_we_i,
  input  logic [kvc_pkg::KLEN_W-1:0]    cfg_wdata_i,
  // input stream
  input  logic                          s_axis_tvalid,
  output logic                          s_axis_tready,
  // row[4:0], column[9:5], key_index[15:10], char_in[23:16], first[24], zero[31:25]
  input  logic [kvc_pkg::TDATA_W-1:0]   s_axis_tdata,
  // op[1:0]
  input  logic [kvc_pkg::TUSER_W-1:0]   s_axis_tuser,
  // result stream
  output logic                          m_axis_tvalid,
  input  logic                          m_axis_tready,
  // char_out[7:0]
  output logic [kvc_pkg::OUT_W-1:0]     m_axis_tdata
);
  import kvc_pkg::*;

  // command and status between controller and datapath
  kvc_cmd_t cmd;
  kvc_sts_t sts;

  // controller: one item at a time, result parked in the output register
  kvc_ctrl u_ctrl (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .s_valid_i (s_axis_tvalid),
    .s_ready_o (s_axis_tready),
    .sts_i     (sts),
    .cmd_o     (cmd)
  );

  // datapath: key store, tableau memory, row 0 and column 0 copies, output stage
  kvc_datapath u_datapath (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_wdata_i (cfg_wdata_i),
    .in_data_i   (s_axis_tdata),
    .in_user_i   (s_axis_tuser),
    .cmd_i       (cmd),
    .sts_o       (sts),
    .out_valid_o (m_axis_tvalid),
    .out_ready_i (m_axis_tready),
    .out_data_o  (m_axis_tdata)
  );

endmodule

// ----- verif/tb.sv -----
// self-checking testbench for the keyed tableau vigenere cipher core
`timescale 1ns / 100ps

module tb;
  import kvc_pkg::*;

  // longest item without a result (decrypt, no column match) plus margin
  localparam int unsigned SETTLE = 40;

  logic                clk_i         = 1'b0;
  logic                rst_ni        = 1'b0;
  logic                cfg_we_i      = 1'b0;
  logic [KLEN_W-1:0]   cfg_wdata_i   = '0;
  logic                s_axis_tvalid = 1'b0;
  logic                s_axis_tready;
  // row[4:0], column[9:5], key_index[15:10], char_in[23:16], first[24], zero[31:25]
  logic [TDATA_W-1:0]  s_axis_tdata  = '0;
  // op[1:0]
  logic [TUSER_W-1:0]  s_axis_tuser  = '0;
  logic                m_axis_tvalid;
  logic                m_axis_tready = 1'b0;
  // char_out[7:0]
  logic [OUT_W-1:0]    m_axis_tdata;

  keyed_tableau_vigenere_cipher_core u_top (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cfg_we_i      (cfg_we_i),
    .cfg_wdata_i   (cfg_wdata_i),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata)
  );

  // 8 ns clock
  always begin
    #4 clk_i = 1'b1;
    #4 clk_i = 1'b0;
  end

  // mirror of the block state, updated at each accepted input transaction
  logic [CHAR_W-1:0] tab_mem [TAB_DEPTH];
  logic [CHAR_W-1:0] key_mem [KEY_MAX];
  logic [KLEN_W-1:0] key_len = 7'd1;
  int unsigned       key_pos = 0;

  // text alphabet used to build the tableau, always includes 8'h00 and 8'hff
  logic [CHAR_W-1:0] alpha [ALPHA];
  bit                in_alpha [256];

  logic [CHAR_W-1:0] cipher_q [$];   // characters still owed by the block
  bit                calm = 1'b0;    // no idling on either side while set

  int n_text, n_quiet, n_tab, n_key, n_cfg, n_results, n_errors;

  // one text character through the cipher; returns 1 when a character comes out
  function automatic bit vigenere_predict(input kvc_op_e op, input logic [7:0] ch,
                                          input bit first, output logic [7:0] res);
    int unsigned len, p, r, c, srow;
    int          j;
    logic [7:0]  kc;
    len = (key_len == 0) ? 1 : (key_len > KEY_MAX) ? KEY_MAX : key_len;
    p = first ? 0 : key_pos;
    if (p >= len) p = 0;   // position left over from a longer key
    kc = key_mem[p];
    // lowest row whose first cell is the key character
    r = ALPHA;
    for (j = ALPHA - 1; j >= 0; j--)
      if (tab_mem[j * ALPHA] == kc) r = j;
    c = ALPHA;
    res = '0;
    if (r < ALPHA) begin
      // decrypt searches the key row, encrypt searches row 0; lowest column wins
      srow = (op == OP_DECRYPT) ? r : 0;
      for (j = ALPHA - 1; j >= 0; j--)
        if (tab_mem[srow * ALPHA + j] == ch) c = j;
      if (c < ALPHA) res = (op == OP_DECRYPT) ? tab_mem[c] : tab_mem[r * ALPHA + c];
    end
    key_pos = (p + 1 >= len) ? 0 : p + 1;
    return (c < ALPHA);
  endfunction

  function automatic logic [7:0] rand_alpha();
    return alpha[$urandom_range(0, ALPHA - 1)];
  endfunction

  function automatic logic [7:0] absent_char();
    logic [7:0] v;
    do v = 8'($urandom_range(0, 255)); while (in_alpha[v]);
    return v;
  endfunction

  // drive one input transaction, wait for its acceptance, update the mirror
  task automatic send_item(input kvc_op_e op, input logic [4:0] row, input logic [4:0] col,
                           input logic [5:0] kidx, input logic [7:0] ch, input bit first);
    logic [7:0] res;
    @(negedge clk_i);
    while (!calm && $urandom_range(0, 99) < 36) begin
      s_axis_tvalid <= 1'b0;
      @(negedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tuser  <= op;
    s_axis_tdata  <= {7'd0, first, ch, kidx, col, row};
    @(posedge clk_i);
    while (!s_axis_tready) @(posedge clk_i);
    case (op)
      OP_TAB_LOAD: begin
        n_tab++;
        if (row < ALPHA && col < ALPHA) tab_mem[row * ALPHA + col] = ch;
      end
      OP_KEY_LOAD: begin
        n_key++;
        key_mem[kidx] = ch;
      end
      default: begin
        n_text++;
        if (vigenere_predict(op, ch, first, res)) cipher_q = {cipher_q, res};
        else n_quiet++;
      end
    endcase
  endtask

  // unused fields of each kind of transaction carry random bits
  task automatic load_cell(input logic [4:0] row, input logic [4:0] col, input logic [7:0] v);
    send_item(OP_TAB_LOAD, row, col, 6'($urandom_range(0, 63)), v,
              1'($urandom_range(0, 1)));
  endtask

  task automatic load_key(input logic [5:0] kidx, input logic [7:0] v);
    send_item(OP_KEY_LOAD, 5'($urandom_range(0, 31)), 5'($urandom_range(0, 31)), kidx, v,
              1'($urandom_range(0, 1)));
  endtask

  task automatic send_text(input kvc_op_e op, input logic [7:0] ch, input bit first);
    send_item(op, 5'($urandom_range(0, 31)), 5'($urandom_range(0, 31)),
              6'($urandom_range(0, 63)), ch, first);
  endtask

  // stop sending, collect every owed character, then let a silent item finish
  task automatic wait_idle();
    @(negedge clk_i);
    s_axis_tvalid <= 1'b0;
    while (cipher_q.size() != 0) @(posedge clk_i);
    repeat (SETTLE) @(posedge clk_i);
  endtask

  task automatic set_key_length(input logic [KLEN_W-1:0] v);
    wait_idle();
    @(negedge clk_i);
    cfg_we_i    <= 1'b1;
    cfg_wdata_i <= v;
    @(negedge clk_i);
    cfg_we_i    <= 1'b0;
    key_len = v;
    n_cfg++;
  endtask

  // every tableau cell and key entry is written before any text is sent
  task automatic test_fill_tables();
    logic [7:0] v;
    int         i, r, c;
    alpha[0] = 8'h00;
    alpha[ALPHA - 1] = 8'hff;
    in_alpha[8'h00] = 1'b1;
    in_alpha[8'hff] = 1'b1;
    for (i = 1; i < ALPHA - 1; i++) begin
      do v = 8'($urandom_range(1, 254)); while (in_alpha[v]);
      in_alpha[v] = 1'b1;
      alpha[i] = v;
    end
    // shifted rows: row r, column c holds alpha[(r + c) mod 26]
    for (r = 0; r < ALPHA; r++)
      for (c = 0; c < ALPHA; c++)
        load_cell(5'(r), 5'(c), alpha[(r + c) % ALPHA]);
    for (i = 0; i < KEY_MAX; i++) load_key(6'(i), rand_alpha());
  endtask

  // loads outside the tableau must change nothing
  task automatic test_ignored_loads();
    load_cell(5'd31, 5'd0, 8'h5a);
    load_cell(5'd0, 5'd26, 8'ha5);
    load_cell(5'd26, 5'd31, 8'h3c);
  endtask

  // extreme characters and the last column, key length still at its reset value
  task automatic test_extreme_chars();
    load_key(6'd0, alpha[2]);
    send_text(OP_DECRYPT, 8'h00, 1'b1);
    send_text(OP_DECRYPT, 8'hff, 1'b0);
    send_text(OP_ENCRYPT, 8'h00, 1'b0);
    send_text(OP_ENCRYPT, 8'hff, 1'b1);
    send_text(OP_DECRYPT, alpha[1], 1'b0);  // found in the last column of row 2
  endtask

  // two rows with the same first cell, two columns with the same character
  task automatic test_duplicate_matches();
    load_cell(5'd5, 5'd0, alpha[2]);
    send_text(OP_ENCRYPT, alpha[4], 1'b1);
    load_cell(5'd0, 5'd7, alpha[3]);
    send_text(OP_ENCRYPT, alpha[3], 1'b0);
    load_cell(5'd2, 5'd9, alpha[4]);
    send_text(OP_DECRYPT, alpha[4], 1'b0);
    load_cell(5'd5, 5'd0, alpha[5]);
    load_cell(5'd0, 5'd7, alpha[7]);
    load_cell(5'd2, 5'd9, alpha[11]);
  endtask

  // no row for the key character, then no column for the text character
  task automatic test_no_match();
    load_key(6'd0, absent_char());
    send_text(OP_DECRYPT, alpha[1], 1'b1);
    load_key(6'd0, alpha[2]);
    send_text(OP_DECRYPT, absent_char(), 1'b0);
    send_text(OP_ENCRYPT, absent_char(), 1'b0);
  endtask

  // advance the position under a long key, then shorten the key below it
  task automatic test_stale_position();
    int i;
    set_key_length(7'd64);
    for (i = 0; i < 5; i++) send_text(OP_ENCRYPT, rand_alpha(), i == 0);
    set_key_length(7'd3);
    send_text(OP_ENCRYPT, rand_alpha(), 1'b0);
    set_key_length(7'd0);    // acts as a one-character key
    send_text(OP_DECRYPT, rand_alpha(), 1'b0);
    send_text(OP_ENCRYPT, rand_alpha(), 1'b0);
  endtask

  // messages of random text under several key lengths, with sparse reloads
  task automatic test_random_phases();
    logic [KLEN_W-1:0] lens [8];
    int                ph, i, sel;
    lens = '{7'd5, 7'd64, 7'd127, 7'd1, 7'd65, 7'd0, 7'd13, 7'd0};
    lens[5] = 7'($urandom_range(2, 63));
    for (ph = 0; ph < 8; ph++) begin
      set_key_length(lens[ph]);
      calm = (ph == 2);
      for (i = 0; i < 135; i++) begin
        sel = $urandom_range(0, 99);
        if (sel < 4)
          load_cell(5'($urandom_range(0, 31)), 5'($urandom_range(0, 31)),
                    ($urandom_range(0, 9) == 0) ? 8'($urandom_range(0, 255)) : rand_alpha());
        else if (sel < 8)
          load_key(6'($urandom_range(0, 63)),
                   ($urandom_range(0, 9) == 0) ? 8'($urandom_range(0, 255)) : rand_alpha());
        else
          send_text($urandom_range(0, 1) ? OP_ENCRYPT : OP_DECRYPT,
                    ($urandom_range(0, 9) == 0) ? 8'($urandom_range(0, 255)) : rand_alpha(),
                    $urandom_range(0, 99) < 8);
      end
      calm = 1'b0;
    end
  endtask

  // result side stalls at random, except during the calm stretch
  always @(negedge clk_i) begin
    m_axis_tready <= calm || ($urandom_range(0, 99) >= 36);
  end

  // compare each result transaction with the oldest owed character
  always @(posedge clk_i) begin
    logic [7:0] want;
    if (rst_ni && m_axis_tvalid && m_axis_tready) begin
      if (cipher_q.size() == 0) begin
        $error("char_out: no result expected, got %02h", m_axis_tdata);
        n_errors++;
      end else begin
        want = cipher_q.pop_front();
        n_results++;
        if (m_axis_tdata !== want) begin
          $error("char_out: expected %02h, got %02h", want, m_axis_tdata);
          n_errors++;
        end
      end
    end
  end

  initial begin
    repeat (2) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;
    test_fill_tables();
    test_ignored_loads();
    test_extreme_chars();
    test_duplicate_matches();
    test_no_match();
    test_stale_position();
    test_random_phases();
    wait_idle();
    $display("covered %0d tableau loads and %0d key loads over %0d key length writes",
             n_tab, n_key, n_cfg);
    $display("covered %0d text characters: %0d results checked, %0d without a result",
             n_text, n_results, n_quiet);
    if (n_errors == 0 && cipher_q.size() == 0) begin
      $display("PASSED: all results match");
    end else begin
      $display("FAILED: results differ");
    end
    $finish;
  end

  // safety net far beyond the slowest correct run
  initial begin
    #5_000_000;
    $display("FAILED: results differ");
    $finish;
  end

endmodule

// ----- keyed_tableau_vigenere_cipher_core.f -----
sv/kvc_pkg.sv
sv/kvc_ctrl.sv
sv/kvc_datapath.sv
sv/keyed_tableau_vigenere_cipher_core.sv
verif/tb.sv
